// ===== hw/rtl/threshold_run_cluster_finder_unit_assert.svh =====
// assertion macros for the strip cluster finder checker
// both expect clk and rst_n in scope
`ifndef THRESHOLD_RUN_CLUSTER_FINDER_UNIT_ASSERT_SVH
`define THRESHOLD_RUN_CLUSTER_FINDER_UNIT_ASSERT_SVH

// same-cycle implication
`define TRCF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TRCF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/trcf_pkg.sv =====
// ----------------------------------------------------------------------------
// trcf_pkg
// Shared types and constants of the threshold run cluster finder.
// ----------------------------------------------------------------------------
`default_nettype none

package trcf_pkg;

    localparam int CHANNELS_PER_PLANE_DEF = 32;
    localparam int PLANE_COUNT_DEF        = 2;
    localparam int SAMPLE_BITS_DEF        = 12;

    localparam int CHANNEL_W  = 6;
    localparam int SAMPLE_W   = 12;
    localparam int LENGTH_W   = 6;
    localparam int CENTROID_W = 6;

    typedef enum logic {
        OP_THRESHOLD_WRITE = 1'b0,
        OP_SAMPLE          = 1'b1
    } trcf_op_t;

    typedef struct packed {
        logic                  emit;
        logic                  plane;
        logic [LENGTH_W-1:0]   length;
        logic [CENTROID_W-1:0] centroid;
    } trcf_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/trcf_ram.sv =====
// ----------------------------------------------------------------------------
// trcf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module trcf_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/trcf_tracker.sv =====
// ----------------------------------------------------------------------------
// trcf_tracker
// Run tracker: hit test against the threshold and cluster open/close logic.
// ----------------------------------------------------------------------------
`default_nettype none

module trcf_tracker #(
    parameter int CHANNELS_PER_PLANE = 32,
    parameter int PLANE_COUNT        = 2,
    parameter int SAMPLE_BITS        = 12,
    localparam int PW  = $clog2(CHANNELS_PER_PLANE),
    localparam int PLW = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic [PLW-1:0]         plane,
    input  logic [PW-1:0]          pos,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [SAMPLE_BITS-1:0] threshold,
    output trcf_pkg::trcf_result_t result
);

    import trcf_pkg::*;

    localparam int RW  = PW + 1;
    localparam int CNW = PW + 2;

    logic           in_cluster_reg, in_cluster_next;
    logic [PW-1:0]  start_reg, start_next;
    logic [RW-1:0]  run_reg, run_next;
    logic [PLW-1:0] plane_reg, plane_next;

    logic           cont;
    logic           hit;
    logic           last;
    logic           emit;
    logic [PW-1:0]  new_start;
    logic [RW-1:0]  new_run;
    logic [PLW-1:0] new_plane;
    logic [PW-1:0]  res_start;
    logic [RW-1:0]  res_run;
    logic [PLW-1:0] res_plane;
    logic [CNW-1:0] centroid;

    // the sample continues the open run only at the next adjacent position
    assign cont = in_cluster_reg && (plane == plane_reg)
                  && (RW'(pos) == RW'(start_reg) + run_reg);
    assign hit  = sample > threshold;
    assign last = pos == PW'(CHANNELS_PER_PLANE - 1);

    assign new_start = cont ? start_reg : pos;
    assign new_plane = cont ? plane_reg : plane;
    assign new_run   = (cont ? run_reg : RW'(0)) + RW'(1);

    // a hit at the last position closes the run it just extended, a miss closes the old one
    assign res_start = hit ? new_start : start_reg;
    assign res_run   = hit ? new_run   : run_reg;
    assign res_plane = hit ? new_plane : plane_reg;
    assign centroid  = (CNW'(res_start) << 1) + CNW'(res_run) - CNW'(1);

    always_comb
    begin
        in_cluster_next = in_cluster_reg;
        start_next      = start_reg;
        run_next        = run_reg;
        plane_next      = plane_reg;
        emit            = 1'b0;
        if (step)
        begin
            if (hit)
            begin
                start_next = new_start;
                plane_next = new_plane;
                if (last)
                begin
                    emit            = 1'b1;
                    in_cluster_next = 1'b0;
                    run_next        = '0;
                end
                else
                begin
                    in_cluster_next = 1'b1;
                    run_next        = new_run;
                end
            end
            else
            begin
                // a miss at the next adjacent position closes the run with a transaction; else the run is dropped
                emit            = cont;
                in_cluster_next = 1'b0;
                run_next        = '0;
            end
        end
    end

    assign result.emit     = emit;
    assign result.plane    = res_plane[0];
    assign result.length   = LENGTH_W'(res_run);
    assign result.centroid = CENTROID_W'(centroid);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_cluster_reg <= 1'b0;
            start_reg      <= '0;
            run_reg        <= '0;
            plane_reg      <= '0;
        end
        else
        begin
            in_cluster_reg <= in_cluster_next;
            start_reg      <= start_next;
            run_reg        <= run_next;
            plane_reg      <= plane_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/threshold_run_cluster_finder_unit.sv =====
// ----------------------------------------------------------------------------
// threshold_run_cluster_finder_unit
// Path: a closing sample is registered in the s1 stage, then its cluster in the output register.
// Throughput: one transaction per cycle unless cluster_ready stalls the output; the threshold RAM read is registered.
// Reset clears the run tracker and both valid flags; thresholds are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module threshold_run_cluster_finder_unit #(
    parameter int CHANNELS_PER_PLANE = trcf_pkg::CHANNELS_PER_PLANE_DEF,
    parameter int PLANE_COUNT        = trcf_pkg::PLANE_COUNT_DEF,
    parameter int SAMPLE_BITS        = trcf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             sample_valid,
    output logic                             sample_ready,
    input  logic                             operation,
    input  logic [trcf_pkg::CHANNEL_W-1:0]   channel,
    input  logic [trcf_pkg::SAMPLE_W-1:0]    sample_value,
    output logic                             cluster_valid,
    input  logic                             cluster_ready,
    output logic                             plane,
    output logic [trcf_pkg::LENGTH_W-1:0]    cluster_length,
    output logic [trcf_pkg::CENTROID_W-1:0]  centroid_doubled
);

    import trcf_pkg::*;

    localparam int TABLE_DEPTH = CHANNELS_PER_PLANE * PLANE_COUNT;
    localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int PW  = $clog2(CHANNELS_PER_PLANE);
    localparam int PLW = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;

    logic                   accept;
    logic                   advance;
    logic                   in_range;
    logic [PLW-1:0]         plane_in;
    logic [PW-1:0]          pos_in;
    logic [SAMPLE_BITS-1:0] value_in;
    logic [SAMPLE_BITS-1:0] threshold;
    trcf_result_t           result;

    logic                   s1_valid_reg;
    logic [PLW-1:0]         s1_plane_reg;
    logic [PW-1:0]          s1_pos_reg;
    logic [SAMPLE_BITS-1:0] s1_value_reg;

    logic                   out_valid_reg;
    logic                   out_plane_reg;
    logic [LENGTH_W-1:0]    out_length_reg;
    logic [CENTROID_W-1:0]  out_centroid_reg;

    // split the channel into plane and position
    always_comb
    begin
        in_range = 1'b0;
        plane_in = '0;
        pos_in   = '0;
        for (int p = 0; p < PLANE_COUNT; p++)
        begin
            if (32'(channel) >= p * CHANNELS_PER_PLANE
                && 32'(channel) < (p + 1) * CHANNELS_PER_PLANE)
            begin
                in_range = 1'b1;
                plane_in = PLW'(p);
                pos_in   = PW'(32'(channel) - p * CHANNELS_PER_PLANE);
            end
        end
    end

    assign value_in     = SAMPLE_BITS'(sample_value);
    assign accept       = sample_valid && sample_ready;
    assign advance      = s1_valid_reg && (!out_valid_reg || cluster_ready);
    assign sample_ready = !s1_valid_reg || advance;

    trcf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_threshold_ram (
        .clk     (clk),
        .wr_en   (accept && (operation == OP_THRESHOLD_WRITE) && in_range),
        .wr_addr (AW'(channel)),
        .wr_data (value_in),
        .rd_en   (accept),
        .rd_addr (AW'(channel)),
        .rd_data (threshold)
    );

    // only in-range samples go on to the tracker
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (sample_ready)
        begin
            s1_valid_reg <= sample_valid && (operation == OP_SAMPLE) && in_range;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_plane_reg <= plane_in;
            s1_pos_reg   <= pos_in;
            s1_value_reg <= value_in;
        end
    end

    trcf_tracker #(
        .CHANNELS_PER_PLANE (CHANNELS_PER_PLANE),
        .PLANE_COUNT        (PLANE_COUNT),
        .SAMPLE_BITS        (SAMPLE_BITS)
    ) u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .plane     (s1_plane_reg),
        .pos       (s1_pos_reg),
        .sample    (s1_value_reg),
        .threshold (threshold),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || cluster_ready)
        begin
            out_valid_reg <= advance && result.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || cluster_ready)
        begin
            out_plane_reg    <= result.plane;
            out_length_reg   <= result.length;
            out_centroid_reg <= result.centroid;
        end
    end

    assign cluster_valid    = out_valid_reg;
    assign plane            = out_plane_reg;
    assign cluster_length   = out_length_reg;
    assign centroid_doubled = out_centroid_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/trcf_checker.sv =====
// ----------------------------------------------------------------------------
// trcf_checker
// Port-level checks of the cluster finder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "threshold_run_cluster_finder_unit_assert.svh"

module trcf_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             sample_valid,
    input  logic                             sample_ready,
    input  logic                             operation,
    input  logic                             cluster_valid,
    input  logic                             cluster_ready,
    input  logic                             plane,
    input  logic [trcf_pkg::LENGTH_W-1:0]    cluster_length,
    input  logic [trcf_pkg::CENTROID_W-1:0]  centroid_doubled
);

    import trcf_pkg::*;

    logic sample_accept;

    assign sample_accept = sample_valid && sample_ready && (operation == OP_SAMPLE);

    `TRCF_ASSERT_NXT(a_out_hold, cluster_valid && !cluster_ready,
        cluster_valid && $stable(plane) && $stable(cluster_length)
        && $stable(centroid_doubled), "stalled cluster transaction changed")

    // input is only held off by a stalled result
    `TRCF_ASSERT_IMP(a_ready_stall, !sample_ready,
        cluster_valid && !cluster_ready, "input stalled without output backpressure")

    // a fresh cluster comes from an earlier accepted sample that passed the s1 register
    `TRCF_ASSERT_IMP(a_cluster_source, $rose(cluster_valid),
        $past(sample_accept, 2), "cluster transaction without a closing sample")

    // 2*start + length - 1 has the opposite parity of the length
    `TRCF_ASSERT_IMP(a_centroid_parity, cluster_valid,
        centroid_doubled[0] != cluster_length[0], "centroid parity mismatch")

endmodule

bind threshold_run_cluster_finder_unit trcf_checker u_trcf_checker (.*);

`default_nettype wire
